// ===== rtl/core/sfm_pkg.sv =====
// Shared types and constants of the stereo FIR wet/dry mixer.
// Holds the datapath command and status structs, operation codes and fixed widths.
// No dependencies.
`default_nettype none

package sfm_pkg;

  localparam int unsigned DATA_W = 24;
  localparam int unsigned HALF_W = 10;
  localparam int unsigned MIX_W  = 17;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned MUL_W  = 25;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned SPLIT  = 23;

  localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

  localparam logic signed [ACC_W-1:0] RND22   = 64'sd2097152;
  localparam logic signed [ACC_W-1:0] RND20   = 64'sd524288;
  localparam logic signed [ACC_W-1:0] RND16   = 64'sd32768;
  localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sd8388608;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_COEF   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    REG_HALF = 2'd0,
    REG_MIX  = 2'd1,
    REG_GAIN = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_MAC     = 4'd1,
    OP_WET     = 4'd2,
    OP_GAIN_LO = 4'd3,
    OP_GAIN_HI = 4'd4,
    OP_WG      = 4'd5,
    OP_MIX_LO  = 4'd6,
    OP_MIX_HI  = 4'd7,
    OP_DRY     = 4'd8,
    OP_OUT     = 4'd9
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic tap_wr;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic mac_last;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfm_datapath.sv =====
// Datapath of the stereo FIR wet/dry mixer: delay line and tap memories,
// address counters, two multiply-accumulate lanes and the output register.
// Depends on sfm_pkg; driven by sfm_ctrl through cmd_t and status_t.
`default_nettype none

module sfm_datapath import sfm_pkg::*; #(
  parameter int unsigned MAX_HALF_TAPS = 512
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic        [HALF_W-1:0] half_i,
  input  logic        [HALF_W:0]   len_i,
  input  logic        [MIX_W-1:0]  mix_i,
  input  logic        [GAIN_W-1:0] gain_i,
  input  logic signed [DATA_W-1:0] wet_left_i,
  input  logic signed [DATA_W-1:0] wet_right_i,
  input  logic signed [DATA_W-1:0] dry_left_i,
  input  logic signed [DATA_W-1:0] dry_right_i,
  input  logic        [IDX_W-1:0]  coef_index_i,
  input  logic signed [DATA_W-1:0] coef_value_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] out_left_o,
  output logic signed [DATA_W-1:0] out_right_o
);

  localparam int unsigned DEPTH = 2 * MAX_HALF_TAPS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = ((AW > HALF_W + 1) ? AW : HALF_W + 1) + 1;
  localparam int unsigned WET_W = 26 + AW;
  localparam int unsigned WG_W  = WET_W + 4;
  localparam int unsigned HI_W  = WET_W - SPLIT;
  localparam int unsigned WGH_W = WG_W - SPLIT;

  logic [DATA_W-1:0] wet_l_mem [DEPTH];
  logic [DATA_W-1:0] wet_r_mem [DEPTH];
  logic [DATA_W-1:0] dry_l_mem [DEPTH];
  logic [DATA_W-1:0] dry_r_mem [DEPTH];
  logic [DATA_W-1:0] tap_mem   [DEPTH];

  logic [AW-1:0] wpos_q, wpos_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] j_q, j_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [CW-1:0] len_c, half_c, ahead_sum, pos_inc, k_inc, j_inc;
  logic [AW-1:0] pos_cur, ahead, wpos_nxt, k_nxt;

  logic              wet_we, dry_we, tap_we, idx_ok;
  logic [AW-1:0]     wet_waddr, dry_waddr, tap_waddr;
  logic [DATA_W-1:0] wet_l_wdata, wet_r_wdata, dry_l_wdata, dry_r_wdata, tap_wdata;

  logic signed [DATA_W-1:0] wet_rd_q [2];
  logic signed [DATA_W-1:0] dry_rd_q [2];
  logic signed [DATA_W-1:0] tap_rd_q;

  op_e op1_q, op2_q;

  logic signed [MUL_W-1:0]  mul_a [2];
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_d [2];
  logic signed [PROD_W-1:0] prod_q [2];

  logic signed [ACC_W-1:0]  acc_q [2];
  logic signed [ACC_W-1:0]  addend [2];
  logic signed [ACC_W-1:0]  acc_sum [2];
  logic signed [ACC_W-1:0]  rnd22 [2];
  logic signed [ACC_W-1:0]  rnd20 [2];
  logic signed [ACC_W-1:0]  rnd16 [2];
  logic signed [ACC_W-1:0]  out_c [2];

  logic signed [WET_W-1:0]  wet_q [2];
  logic signed [HI_W-1:0]   wet_hi [2];
  logic signed [WG_W-1:0]   wg_q [2];
  logic signed [WGH_W-1:0]  wg_hi [2];
  logic signed [DATA_W-1:0] out_q [2];
  logic                     out_valid_q;

  // Addressing of the circular lines.
  always_comb begin
    half_c    = CW'(half_i);
    len_c     = CW'(len_i);
    pos_cur   = (CW'(wpos_q) >= len_c) ? '0 : wpos_q;
    ahead_sum = CW'(pos_cur) + half_c;
    ahead     = (ahead_sum >= len_c) ? AW'(ahead_sum - len_c) : AW'(ahead_sum);
    pos_inc   = CW'(pos_cur) + CW'(1);
    wpos_nxt  = (pos_inc >= len_c) ? '0 : AW'(pos_inc);
    k_inc     = CW'(k_q) + CW'(1);
    k_nxt     = (k_inc >= len_c) ? '0 : AW'(k_inc);
    j_inc     = CW'(j_q) + CW'(1);

    wpos_d = wpos_q;
    k_d    = k_q;
    j_d    = j_q;
    clr_d  = clr_q;
    if (cmd_i.clr) begin
      clr_d = clr_q + AW'(1);
    end
    if (cmd_i.load) begin
      wpos_d = wpos_nxt;
      k_d    = pos_cur;
      j_d    = '0;
    end else if (cmd_i.op == OP_MAC) begin
      k_d = k_nxt;
      j_d = j_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      k_q    <= '0;
      j_q    <= '0;
      clr_q  <= '0;
    end else begin
      wpos_q <= wpos_d;
      k_q    <= k_d;
      j_q    <= j_d;
      clr_q  <= clr_d;
    end
  end

  // Memory write ports: the clearing pass or the accepted item.
  always_comb begin
    idx_ok      = (32'(coef_index_i) < DEPTH);
    wet_we      = cmd_i.clr || cmd_i.load;
    dry_we      = cmd_i.clr || cmd_i.load;
    tap_we      = cmd_i.clr || (cmd_i.tap_wr && idx_ok);
    wet_waddr   = cmd_i.clr ? clr_q : pos_cur;
    dry_waddr   = cmd_i.clr ? clr_q : ahead;
    tap_waddr   = cmd_i.clr ? clr_q : AW'(coef_index_i);
    wet_l_wdata = cmd_i.clr ? '0 : wet_left_i;
    wet_r_wdata = cmd_i.clr ? '0 : wet_right_i;
    dry_l_wdata = cmd_i.clr ? '0 : dry_left_i;
    dry_r_wdata = cmd_i.clr ? '0 : dry_right_i;
    tap_wdata   = cmd_i.clr ? '0 : coef_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (wet_we) begin
      wet_l_mem[wet_waddr] <= wet_l_wdata;
      wet_r_mem[wet_waddr] <= wet_r_wdata;
    end
    wet_rd_q[0] <= wet_l_mem[k_q];
    wet_rd_q[1] <= wet_r_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (dry_we) begin
      dry_l_mem[dry_waddr] <= dry_l_wdata;
      dry_r_mem[dry_waddr] <= dry_r_wdata;
    end
    if (cmd_i.load) begin
      dry_rd_q[0] <= dry_l_mem[pos_cur];
      dry_rd_q[1] <= dry_r_mem[pos_cur];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    tap_rd_q <= tap_mem[j_q];
  end

  // Operand selection and multiply.
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      wet_hi[ch] = $signed(wet_q[ch][WET_W-1:SPLIT]);
      wg_hi[ch]  = $signed(wg_q[ch][WG_W-1:SPLIT]);
      unique case (op1_q)
        OP_MAC:     mul_a[ch] = MUL_W'(wet_rd_q[ch]);
        OP_GAIN_LO: mul_a[ch] = $signed(MUL_W'(wet_q[ch][SPLIT-1:0]));
        OP_GAIN_HI: mul_a[ch] = MUL_W'(wet_hi[ch]);
        OP_MIX_LO:  mul_a[ch] = $signed(MUL_W'(wg_q[ch][SPLIT-1:0]));
        OP_MIX_HI:  mul_a[ch] = MUL_W'(wg_hi[ch]);
        OP_DRY:     mul_a[ch] = MUL_W'(dry_rd_q[ch]);
        default:    mul_a[ch] = '0;
      endcase
    end
    unique case (op1_q)
      OP_MAC:                 mul_b = MUL_W'(tap_rd_q);
      OP_GAIN_LO, OP_GAIN_HI: mul_b = $signed(MUL_W'(gain_i));
      OP_MIX_LO, OP_MIX_HI:   mul_b = $signed(MUL_W'(mix_i));
      OP_DRY:                 mul_b = $signed(MUL_W'(MIX_ONE - mix_i));
      default:                mul_b = '0;
    endcase
    for (int ch = 0; ch < 2; ch++) begin
      prod_d[ch] = mul_a[ch] * mul_b;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q[0] <= prod_d[0];
    prod_q[1] <= prod_d[1];
  end

  // Accumulate, round and saturate.
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      addend[ch] = ACC_W'(prod_q[ch]);
      if ((op2_q == OP_GAIN_HI) || (op2_q == OP_MIX_HI)) begin
        addend[ch] = addend[ch] <<< SPLIT;
      end
      acc_sum[ch] = acc_q[ch] + addend[ch];
      rnd22[ch]   = (acc_q[ch] + RND22) >>> 22;
      rnd20[ch]   = (acc_q[ch] + RND20) >>> 20;
      rnd16[ch]   = (acc_q[ch] + RND16) >>> 16;
      priority if (rnd16[ch] > OUT_MAX) begin
        out_c[ch] = OUT_MAX;
      end else if (rnd16[ch] < OUT_MIN) begin
        out_c[ch] = OUT_MIN;
      end else begin
        out_c[ch] = rnd16[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q       <= OP_NOP;
      op2_q       <= OP_NOP;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      op1_q <= cmd_i.op;
      op2_q <= op1_q;
      for (int ch = 0; ch < 2; ch++) begin
        unique case (op2_q)
          OP_MAC, OP_GAIN_LO, OP_GAIN_HI, OP_MIX_LO, OP_MIX_HI, OP_DRY: begin
            acc_q[ch] <= acc_sum[ch];
          end
          OP_WET, OP_WG, OP_OUT: begin
            acc_q[ch] <= '0;
          end
          default: begin
          end
        endcase
      end
      if (op2_q == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 2; ch++) begin
      if (op2_q == OP_WET) begin
        wet_q[ch] <= $signed(rnd22[ch][WET_W-1:0]);
      end
      if (op2_q == OP_WG) begin
        wg_q[ch] <= $signed(rnd20[ch][WG_W-1:0]);
      end
      if (op2_q == OP_OUT) begin
        out_q[ch] <= $signed(out_c[ch][DATA_W-1:0]);
      end
    end
  end

  always_comb begin
    status_o.mac_last = (j_inc == len_c);
    status_o.clr_last = (clr_q == AW'(DEPTH - 1));
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_q[0];
  assign out_right_o = out_q[1];

`ifndef SYNTHESIS
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op2_q == OP_OUT) |-> !out_valid_q)
    else $error("Output register overwritten while still holding an item.");

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MAC) |-> (CW'(j_q) < len_c))
    else $error("Tap index ran past the circular length.");

  a_dry_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (ahead != pos_cur))
    else $error("Dry write position collides with the dry read position.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sfm_ctrl.sv =====
// Controller of the stereo FIR wet/dry mixer: clearing pass, input handshake
// and the step sequence that drives the datapath.
// Depends on sfm_pkg; drives sfm_datapath through cmd_t and reads status_t.
`default_nettype none

module sfm_ctrl import sfm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    func_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_MAC     = 13'b0000000000100,
    S_WET     = 13'b0000000001000,
    S_GAP_W   = 13'b0000000010000,
    S_GAIN_LO = 13'b0000000100000,
    S_GAIN_HI = 13'b0000001000000,
    S_WG      = 13'b0000010000000,
    S_GAP_G   = 13'b0000100000000,
    S_MIX_LO  = 13'b0001000000000,
    S_MIX_HI  = 13'b0010000000000,
    S_DRY     = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.op     = OP_NOP;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_COEF) begin
            cmd_o.tap_wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd_o.op = OP_MAC;
        if (status_i.mac_last) begin
          state_d = S_WET;
        end
      end
      S_WET: begin
        cmd_o.op = OP_WET;
        state_d  = S_GAP_W;
      end
      S_GAP_W: begin
        state_d = S_GAIN_LO;
      end
      S_GAIN_LO: begin
        cmd_o.op = OP_GAIN_LO;
        state_d  = S_GAIN_HI;
      end
      S_GAIN_HI: begin
        cmd_o.op = OP_GAIN_HI;
        state_d  = S_WG;
      end
      S_WG: begin
        cmd_o.op = OP_WG;
        state_d  = S_GAP_G;
      end
      S_GAP_G: begin
        state_d = S_MIX_LO;
      end
      S_MIX_LO: begin
        cmd_o.op = OP_MIX_LO;
        state_d  = S_MIX_HI;
      end
      S_MIX_HI: begin
        cmd_o.op = OP_MIX_HI;
        state_d  = S_DRY;
      end
      S_DRY: begin
        cmd_o.op = OP_DRY;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_load_then_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (cmd_o.op == OP_MAC))
    else $error("A sample item did not start its tap sweep.");

  a_mac_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MAC) && !status_i.mac_last) |=> (state_q == S_MAC))
    else $error("Tap sweep ended before the last tap.");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("Controller state is not one-hot.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/stereo_fir_wet_dry_mixer_unit.sv =====
// Stereo FIR filter with circular delay lines, delayed dry path and wet/dry mix.
// A sample item first sweeps the taps, one tap per cycle on the two
// multiply-accumulate lanes over twice the effective half length, then runs
// the rounding, gain, wet/dry mix and output steps on the same
// multipliers. A coefficient item is written straight to the taps. The result waits in an
// output register, so the next item is taken while it is not yet collected;
// a sample item whose result is ready while the previous one is still held
// waits in its last step until that one is taken.
// After reset a clearing pass zeroes all 2*MAX_HALF_TAPS entries of the delay
// lines and taps; no item is accepted during it, while register writes are.
// Registers at byte addresses 0, 4 and 8: half length, mix level (Q1.16)
// and output gain (Q4.20). Depends on sfm_pkg, sfm_ctrl and sfm_datapath.
`default_nettype none

module stereo_fir_wet_dry_mixer_unit import sfm_pkg::*; #(
  parameter int unsigned MAX_HALF_TAPS = 512
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic        [ADDR_W-1:0] paddr,
  input  logic       [PDATA_W-1:0] pwdata,
  output logic       [PDATA_W-1:0] prdata,
  output logic                     pready,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic signed [DATA_W-1:0] wet_left_i,
  input  logic signed [DATA_W-1:0] wet_right_i,
  input  logic signed [DATA_W-1:0] dry_left_i,
  input  logic signed [DATA_W-1:0] dry_right_i,
  input  logic        [IDX_W-1:0]  coef_index_i,
  input  logic signed [DATA_W-1:0] coef_value_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] out_left_o,
  output logic signed [DATA_W-1:0] out_right_o
);

  logic [HALF_W-1:0] half_q;
  logic [MIX_W-1:0]  mix_q;
  logic [GAIN_W-1:0] gain_q;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  logic [HALF_W-1:0] half_eff;
  logic [HALF_W:0]   len_eff;
  logic [MIX_W-1:0]  mix_eff;

  cmd_t    cmd;
  status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 10'd512;
      mix_q  <= 17'd65536;
      gain_q <= 24'd1048576;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HALF: half_q <= pwdata[HALF_W-1:0];
        REG_MIX:  mix_q  <= pwdata[MIX_W-1:0];
        REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HALF: prdata = PDATA_W'(half_q);
      REG_MIX:  prdata = PDATA_W'(mix_q);
      REG_GAIN: prdata = PDATA_W'(gain_q);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    priority if (half_q == '0) begin
      half_eff = HALF_W'(1);
    end else if (32'(half_q) > MAX_HALF_TAPS) begin
      half_eff = HALF_W'(MAX_HALF_TAPS);
    end else begin
      half_eff = half_q;
    end
    len_eff = {half_eff, 1'b0};
    mix_eff = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;
  end

  sfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  sfm_datapath #(
    .MAX_HALF_TAPS (MAX_HALF_TAPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .half_i       (half_eff),
    .len_i        (len_eff),
    .mix_i        (mix_eff),
    .gain_i       (gain_q),
    .wet_left_i   (wet_left_i),
    .wet_right_i  (wet_right_i),
    .dry_left_i   (dry_left_i),
    .dry_right_i  (dry_right_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_left_o   (out_left_o),
    .out_right_o  (out_right_o)
  );

endmodule

`default_nettype wire
